>>> rtl/isgr_pkg.sv
// Shared types, constants and helpers for the independent set repair block.
// No dependencies; imported by every module under rtl/.
package isgr_pkg;

   localparam int MaxVertices = 32;                  // adjacency store depth
   localparam int SetW        = 32;                  // vertex set / row width
   localparam int CountW      = 6;                   // vertex_count field width
   localparam int ReqRowW     = 5;                   // row_index field width
   localparam int RowAddrW    = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
   localparam int SetIdxW     = $clog2(SetW);
   localparam int MaxCount    = (MaxVertices < SetW) ? MaxVertices : SetW;

   localparam int DataW  = 32;
   localparam int PaddrW = 3;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_REPAIR = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic                en;
      logic [RowAddrW-1:0] addr;
   } adj_rd_type;

   typedef struct packed {
      logic                en;
      logic [RowAddrW-1:0] addr;
      logic [SetW-1:0]     data;
   } adj_wr_type;

   function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] vc);
      logic [CountW-1:0] r;
      r = vc;
      if (int'(vc) > MaxCount) r = CountW'(MaxCount);
      return r;
   endfunction

   // bit k set for every vertex k below n
   function automatic logic [SetW-1:0] count_mask(input logic [CountW-1:0] n);
      logic [SetW-1:0] m;
      for (int k = 0; k < SetW; k++) m[k] = (k < int'(n));
      return m;
   endfunction

endpackage

>>> rtl/isgr_adj_mem.sv
// Adjacency row store: one write port, one read port with registered data.
// Per-row valid bits cleared by reset make unwritten rows read as zero. Uses isgr_pkg.
module isgr_adj_mem
   import isgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  adj_wr_type      wr,
   input  adj_rd_type      rd,
   output logic [SetW-1:0] rd_data
);

   logic [SetW-1:0]        mem_ff [MaxVertices];
   logic [MaxVertices-1:0] row_valid_ff;
   logic [SetW-1:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr.en) begin
         row_valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= row_valid_ff[rd.addr] ? mem_ff[rd.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/isgr_engine.sv
// Repair sequencer: streams adjacency rows out of the store, one per cycle,
// and applies the deletion pass then the greedy add-back pass. Uses isgr_pkg.
module isgr_engine
   import isgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SetW-1:0]   candidate,
   input  logic [CountW-1:0] vertex_count,
   output logic              busy,
   output adj_rd_type        rd,
   input  logic [SetW-1:0]   rd_data,
   input  logic              out_free,
   output logic              done,
   output logic [SetW-1:0]   result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_P1   = 2'd1;
   localparam logic [1:0] ST_P2   = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CountW-1:0]  issue_ff, issue_in;
   logic [CountW-1:0]  n_ff, n_in;
   logic [SetW-1:0]    mask_ff, mask_in;
   logic [SetW-1:0]    set_ff, set_in;
   logic               proc_valid_ff, proc_valid_in;
   logic               proc_pass_ff, proc_pass_in;
   logic [SetIdxW-1:0] proc_idx_ff, proc_idx_in;

   logic [CountW-1:0]  eff;
   logic [SetW-1:0]    row;
   logic [SetW-1:0]    bit_sel;
   logic [SetW-1:0]    upper;

   assign eff     = eff_count(vertex_count);
   assign row     = rd_data & mask_ff;
   assign bit_sel = SetW'(1) << proc_idx_ff;
   assign upper   = {SetW{1'b1}} << proc_idx_ff;

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      n_in          = n_ff;
      mask_in       = mask_ff;
      proc_valid_in = 1'b0;
      proc_pass_in  = proc_pass_ff;
      proc_idx_in   = proc_idx_ff;
      rd.en         = 1'b0;
      rd.addr       = issue_ff[RowAddrW-1:0];
      done          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = eff;
               mask_in  = count_mask(eff);
               issue_in = '0;
               state_in = ST_P1;
            end
         end
         ST_P1, ST_P2: begin
            if (issue_ff < n_ff) begin
               rd.en         = 1'b1;
               issue_in      = issue_ff + CountW'(1);
               proc_valid_in = 1'b1;
               proc_pass_in  = (state_ff == ST_P2);
               proc_idx_in   = issue_ff[SetIdxW-1:0];
            end else begin
               // last row of the pass is applied on this edge
               issue_in = '0;
               state_in = (state_ff == ST_P1) ? ST_P2 : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // set update, one vertex per cycle, row data arrives in the cycle after issue
   always_comb begin
      set_in = set_ff;
      if (state_ff == ST_IDLE && start) begin
         set_in = candidate & count_mask(eff);
      end else if (proc_valid_ff) begin
         if (!proc_pass_ff) begin
            if ((set_ff & bit_sel) != '0) set_in = set_ff & ~(row & upper);
         end else begin
            if ((set_ff & bit_sel) == '0 && (set_ff & row) == '0) set_in = set_ff | bit_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         proc_valid_ff <= proc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      mask_ff      <= mask_in;
      set_ff       <= set_in;
      proc_pass_ff <= proc_pass_in;
      proc_idx_ff  <= proc_idx_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign result = set_ff;

   a_set_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((set_ff & ~mask_ff) == '0))
      else $error("working set has bits above vertex count");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1 || state_ff == ST_P2) |-> (issue_ff <= n_ff))
      else $error("row issue ran past vertex count");

   a_proc_bound: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (CountW'(proc_idx_ff) < n_ff))
      else $error("processed vertex beyond vertex count");

   a_done_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ($past(state_ff) == ST_P2 || $past(state_ff) == ST_DONE))
      else $error("result state entered without add-back pass");

endmodule

>>> rtl/independent_set_greedy_repair.sv
// Repair: the result is registered after two passes over n rows (n = effective vertex count),
// paced by the row-per-cycle read port of the adjacency store; the result waits for a free
// output slot, and no new request is taken while the engine is busy with the repair.
// Load: written at the transfer, no result; next request taken the following cycle.
// Reset: store reads all zero (row valid bits cleared), vertex_count = 32, no result pending.
// Depends on isgr_pkg, isgr_adj_mem, isgr_engine.
module independent_set_greedy_repair
   import isgr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [ReqRowW-1:0] req_row_index,
   input  logic [SetW-1:0]    req_adjacency_row,
   input  logic [SetW-1:0]    req_candidate_set,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SetW-1:0]    rsp_repaired_set,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PaddrW-1:0]  csr_paddr,
   input  logic [DataW-1:0]   csr_pwdata,
   output logic [DataW-1:0]   csr_prdata,
   output logic               csr_pready
);

   logic              req_xfer;
   logic              busy;
   logic              done;
   logic              out_free;
   logic [SetW-1:0]   result;
   adj_rd_type        rd;
   adj_wr_type        wr;
   logic [SetW-1:0]   rd_data;

   logic [CountW-1:0] vc_ff, vc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SetW-1:0]   rsp_set_ff;

   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;

   // the store is only read while busy and only written while idle: no overlap
   assign wr.en   = req_xfer && (req_type == REQ_LOAD)
                    && (int'(req_row_index) < MaxVertices);
   assign wr.addr = RowAddrW'(req_row_index);
   assign wr.data = req_adjacency_row;

   isgr_adj_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   isgr_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (req_xfer && (req_type == REQ_REPAIR)),
      .candidate    (req_candidate_set),
      .vertex_count (vc_ff),
      .busy         (busy),
      .rd           (rd),
      .rd_data      (rd_data),
      .out_free     (out_free),
      .done         (done),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_comb begin
      vc_in = vc_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_VERTEX_COUNT) begin
         vc_in = csr_pwdata[CountW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= CountW'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) rsp_set_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_repaired_set = rsp_set_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == REG_VERTEX_COUNT) ? DataW'(vc_ff) : '0;

endmodule
